// ----- design/idt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idt_pkg: shared types and constants of the indentation tracker
// Sizes, character codes, token kinds and the front-to-back command format.
// ----------------------------------------------------------------------------
package idt_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LINE_BITS   = 16;

  localparam int CH_W      = 8;
  localparam int TAB_W     = 4;
  localparam int COUNT_W   = 12;
  localparam int LINE_NO_W = 16;
  localparam int DEPTH_W   = 6;
  localparam int TOP_W     = $clog2(STACK_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [TAB_W-1:0]   TAB_WIDTH_RESET = TAB_W'(4);

  localparam logic [CH_W-1:0] CH_EOI   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_HASH  = 8'h23;

  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [LINE_NO_W-1:0] line_no_t;
  typedef logic [TOP_W-1:0]     top_t;

  typedef enum logic [1:0] {
    TOK_INDENT     = 2'd0,
    TOK_DEDENT     = 2'd1,
    TOK_BAD_DEDENT = 2'd2,
    TOK_OVERFLOW   = 2'd3
  } tok_kind_t;

  // One measured line start handed from the front to the back
  typedef struct packed {
    count_t   space_count;
    line_no_t line_no;
  } cmd_t;

endpackage
`default_nettype wire

// ----- design/idt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module idt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/idt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idt_front: character front end
// Accepts source bytes, counts lines, measures indentation and hands each
// significant line start to the back end as a command.
// ----------------------------------------------------------------------------
module idt_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [idt_pkg::CH_W-1:0]  ch,
  input  wire logic                      in_brackets,
  input  wire logic                      cfg_we,
  input  wire logic [idt_pkg::TAB_W-1:0] cfg_wdata,
  input  wire logic                      q_full,
  output logic                           push,
  output idt_pkg::cmd_t                  push_cmd
);

  typedef enum logic [1:0] {
    PH_MEASURE,
    PH_COMMENT,
    PH_BODY
  } phase_t;

  phase_t                          phase, phase_next;
  idt_pkg::count_t                 space_count, space_count_next;
  logic [idt_pkg::LINE_BITS-1:0]   line_count, line_count_next;
  logic [idt_pkg::TAB_W-1:0]       tab_width;
  logic [idt_pkg::COUNT_W:0]       sum;
  logic                            accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign sum = {1'b0, space_count} +
               ((ch == idt_pkg::CH_TAB) ? (idt_pkg::COUNT_W + 1)'(tab_width)
                                        : (idt_pkg::COUNT_W + 1)'(1));

  assign push_cmd = {space_count, idt_pkg::LINE_NO_W'(line_count)};

  always_comb begin
    phase_next       = phase;
    space_count_next = space_count;
    line_count_next  = line_count;
    push             = 1'b0;
    if (accept) begin
      if (ch == idt_pkg::CH_EOI) begin
        phase_next       = PH_MEASURE;
        space_count_next = '0;
      end else if (ch == idt_pkg::CH_NL) begin
        if (line_count != '1) begin
          line_count_next = line_count + idt_pkg::LINE_BITS'(1);
        end
        phase_next       = PH_MEASURE;
        space_count_next = '0;
      end else if (phase == PH_MEASURE) begin
        if (in_brackets) begin
          // continuation line: no indentation tokens
          phase_next       = PH_BODY;
          space_count_next = '0;
        end else if (ch == idt_pkg::CH_SPACE || ch == idt_pkg::CH_TAB) begin
          space_count_next = sum[idt_pkg::COUNT_W] ? idt_pkg::COUNT_MAX
                                                   : sum[idt_pkg::COUNT_W-1:0];
        end else if (ch == idt_pkg::CH_HASH) begin
          phase_next       = PH_COMMENT;
          space_count_next = '0;
        end else begin
          push             = 1'b1;
          phase_next       = PH_BODY;
          space_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MEASURE;
      space_count <= '0;
      line_count  <= idt_pkg::LINE_BITS'(1);
      tab_width   <= idt_pkg::TAB_WIDTH_RESET;
    end else begin
      phase       <= phase_next;
      space_count <= space_count_next;
      line_count  <= line_count_next;
      if (cfg_we) begin
        tab_width <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/idt_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idt_queue: command queue between front and back
// Short FIFO of line-start commands so each side can stall on its own.
// ----------------------------------------------------------------------------
module idt_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire idt_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output idt_pkg::cmd_t      head_cmd
);

  idt_pkg::cmd_t                  entries [idt_pkg::QUEUE_DEPTH];
  logic [idt_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [idt_pkg::QPTR_W:0]       count;

  assign full       = (count == (idt_pkg::QPTR_W + 1)'(idt_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + idt_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + idt_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (idt_pkg::QPTR_W + 1)'(1);
      end else if (!push && pop) begin
        count <= count - (idt_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/idt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idt_back: indentation stack engine
// Compares each line start with the open levels, pushes or pops the stack
// and drives the token output register.
// ----------------------------------------------------------------------------
module idt_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire idt_pkg::cmd_t               q_cmd,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output idt_pkg::tok_kind_t               out_kind,
  output idt_pkg::line_no_t                out_line,
  output logic [idt_pkg::DEPTH_W-1:0]      out_depth,
  output logic                             out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_EMIT,
    S_ERR
  } state_t;

  state_t             state;
  idt_pkg::top_t      top, top_dec, top_inc;
  idt_pkg::count_t    top_val, cur_sc, nv, ram_rdata;
  idt_pkg::line_no_t  cur_line;
  logic               out_free, above, below, more, err, stack_full;
  logic               ram_we, ram_re, out_load;

  assign out_free   = !out_valid || !out_stall;
  assign above      = q_cmd.space_count > top_val;
  assign below      = q_cmd.space_count < top_val;
  assign top_dec    = top - idt_pkg::TOP_W'(1);
  assign top_inc    = top + idt_pkg::TOP_W'(1);
  assign stack_full = (top == idt_pkg::TOP_W'(idt_pkg::STACK_DEPTH));
  // base level is always zero and never stored
  assign nv         = (top_dec == '0) ? '0 : ram_rdata;
  assign more       = (top_dec != '0) && (cur_sc < nv);
  assign err        = !more && (cur_sc != nv);

  assign q_pop  = (state == S_IDLE) && q_valid && (!above || out_free);
  assign ram_we = q_pop && above && !stack_full;
  assign ram_re = (state == S_POP_RD);
  // a new token enters the output register this cycle
  assign out_load = (q_pop && above) ||
                    ((state == S_POP_EMIT || state == S_ERR) && out_free);

  idt_ram #(
    .WIDTH (idt_pkg::COUNT_W),
    .DEPTH (idt_pkg::STACK_DEPTH + 1)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (top_inc),
    .wdata (q_cmd.space_count),
    .re    (ram_re),
    .raddr (top_dec),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= '0;
      top_val   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (above) begin
              out_line  <= q_cmd.line_no;
              out_last  <= 1'b1;
              if (stack_full) begin
                out_kind  <= idt_pkg::TOK_OVERFLOW;
                out_depth <= idt_pkg::DEPTH_W'(top);
              end else begin
                out_kind  <= idt_pkg::TOK_INDENT;
                out_depth <= idt_pkg::DEPTH_W'(top_inc);
                top       <= top_inc;
                top_val   <= q_cmd.space_count;
              end
            end else if (below) begin
              cur_sc   <= q_cmd.space_count;
              cur_line <= q_cmd.line_no;
              state    <= S_POP_RD;
            end
          end
        end
        S_POP_RD: begin
          state <= S_POP_EMIT;
        end
        S_POP_EMIT: begin
          if (out_free) begin
            out_kind  <= idt_pkg::TOK_DEDENT;
            out_line  <= cur_line;
            out_depth <= idt_pkg::DEPTH_W'(top_dec);
            out_last  <= !(more || err);
            top       <= top_dec;
            top_val   <= nv;
            if (more) begin
              state <= S_POP_RD;
            end else if (err) begin
              state <= S_ERR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_kind  <= idt_pkg::TOK_BAD_DEDENT;
            out_line  <= cur_line;
            out_depth <= idt_pkg::DEPTH_W'(top);
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/indent_dedent_tracker_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// indent_dedent_tracker_top: indentation tracker for line-structured source
//
// Input channel: one source byte (ch) and the upstream bracket flag per
// transaction, taken when in_valid is high and in_stall is low.
// Output channel: INDENT, DEDENT, inconsistent-dedent and overflow tokens,
// one per transaction, with line number, resulting depth and a last flag
// on the final token caused by a byte. The output register lets the input
// keep going while a token waits to be taken.
// An INDENT or overflow token is loaded into the output register as its
// command leaves the queue. Each DEDENT passes S_POP_RD (registered stack
// read) and then S_POP_EMIT; an inconsistent-dedent token follows from S_ERR.
// Throughput: one byte per cycle until the two-entry command queue fills,
// then in_stall holds the input until the stack engine drains it.
// Reset (rst, synchronous): line count 1, depth 0, tab width 4, no tokens.
// A stall on the output holds the stack engine once it has a token to load;
// the front keeps taking bytes until the queue is full.
// cfg_we/cfg_wdata write the tab width; write it only while idle.
// ----------------------------------------------------------------------------
module indent_dedent_tracker_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [idt_pkg::CH_W-1:0]         ch,
  input  wire logic                             in_brackets,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            token_kind,
  output logic [idt_pkg::LINE_NO_W-1:0]         line_no,
  output logic [idt_pkg::DEPTH_W-1:0]           new_depth,
  output logic                                  last,
  input  wire logic                             cfg_we,
  input  wire logic [idt_pkg::TAB_W-1:0]        cfg_wdata
);

  // front to queue
  logic               push, q_full;
  idt_pkg::cmd_t      push_cmd;
  // queue to back
  logic               q_valid, q_pop;
  idt_pkg::cmd_t      q_cmd;
  idt_pkg::tok_kind_t out_kind;

  // Classify bytes, count lines, measure indentation
  idt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ch          (ch),
    .in_brackets (in_brackets),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Decouple front from stack engine
  idt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // Walk the indentation stack and emit tokens
  idt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_line  (line_no),
    .out_depth (new_depth),
    .out_last  (last)
  );

  assign token_kind = out_kind;

  // Overflow only fires with the stack full
  a_overflow_depth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == idt_pkg::TOK_OVERFLOW)
      |-> (new_depth == idt_pkg::DEPTH_W'(idt_pkg::STACK_DEPTH)))
    else $error("overflow token below full stack depth");

  // An INDENT always leaves at least one open level
  a_indent_depth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == idt_pkg::TOK_INDENT) |-> (new_depth != '0))
    else $error("indent token at base depth");

  // Error and overflow tokens always close their byte's token run
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == idt_pkg::TOK_OVERFLOW ||
                   out_kind == idt_pkg::TOK_BAD_DEDENT)) |-> last)
    else $error("error token not marked last");

  // Depth never exceeds the stack size
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (new_depth <= idt_pkg::DEPTH_W'(idt_pkg::STACK_DEPTH)))
    else $error("token depth beyond stack size");

endmodule
`default_nettype wire

// ----- tb/sv/idt_token_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_token_checker: token predictor and scoreboard for the indent tracker
// Watches the byte and token channels and the tab width port. It keeps its
// own copy of the line, column and level-stack state, and it queues the
// tokens that each accepted byte must cause. Each accepted token is checked
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module idt_token_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [idt_pkg::CH_W-1:0]      ch,
  input  logic                          in_brackets,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    token_kind,
  input  logic [idt_pkg::LINE_NO_W-1:0] line_no,
  input  logic [idt_pkg::DEPTH_W-1:0]   new_depth,
  input  logic                          last,
  input  logic                          cfg_we,
  input  logic [idt_pkg::TAB_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            tokens_owed,
  output int                            tokens_checked,
  output int                            overflows_seen,
  output int                            bad_dedents_seen
);
  import idt_pkg::*;

  typedef enum logic [1:0] {
    AT_LINE_START,
    IN_COMMENT,
    IN_BODY
  } line_phase_t;

  typedef struct packed {
    tok_kind_t                kind;
    line_no_t                 line;
    logic [DEPTH_W-1:0]       depth;
    logic                     last;
  } token_t;

  logic [TAB_W-1:0]     tab_cols;
  line_phase_t          line_phase;
  count_t               col;
  count_t               levels [0:STACK_DEPTH];
  top_t                 level_top;
  logic [LINE_BITS-1:0] line_cnt;

  token_t owed_tokens [$];
  token_t staged;
  bit     staged_valid;

  int fails = 0;
  int checked = 0;
  int overflows = 0;
  int bad_dedents = 0;

  // Hold back the newest token so the final one of a byte can get its last flag
  task automatic stage_token(input tok_kind_t kind);
    if (staged_valid) owed_tokens.push_back(staged);
    staged.kind  = kind;
    staged.line  = line_cnt[LINE_NO_W-1:0];
    staged.depth = DEPTH_W'(level_top);
    staged.last  = 1'b0;
    staged_valid = 1'b1;
  endtask

  // First significant byte of a line: compare the column with the open levels
  task automatic resolve_level();
    staged_valid = 1'b0;
    if (col > levels[level_top]) begin
      if (level_top >= STACK_DEPTH) begin
        stage_token(TOK_OVERFLOW);
      end else begin
        level_top = level_top + 1'b1;
        levels[level_top] = col;
        stage_token(TOK_INDENT);
      end
    end else if (col < levels[level_top]) begin
      while (level_top > 0 && col < levels[level_top]) begin
        level_top = level_top - 1'b1;
        stage_token(TOK_DEDENT);
      end
      if (col != levels[level_top]) stage_token(TOK_BAD_DEDENT);
    end
    if (staged_valid) begin
      staged.last = 1'b1;
      owed_tokens.push_back(staged);
    end
  endtask

  task automatic advance_byte(input logic [CH_W-1:0] c, input logic brk);
    logic [COUNT_W:0] sum;
    if (c == CH_EOI) begin
      line_phase = AT_LINE_START;
      col = '0;
    end else if (c == CH_NL) begin
      if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
      line_phase = AT_LINE_START;
      col = '0;
    end else if (line_phase == AT_LINE_START) begin
      if (brk) begin
        line_phase = IN_BODY;
        col = '0;
      end else if (c == CH_SPACE || c == CH_TAB) begin
        sum = {1'b0, col} + ((c == CH_SPACE) ? (COUNT_W+1)'(1) : (COUNT_W+1)'(tab_cols));
        col = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
      end else if (c == CH_HASH) begin
        line_phase = IN_COMMENT;
        col = '0;
      end else begin
        resolve_level();
        line_phase = IN_BODY;
        col = '0;
      end
    end
  endtask

  task automatic check_token();
    token_t want;
    if (owed_tokens.size() == 0) begin
      $error("unexpected token: kind %0d line %0d depth %0d last %0d",
             token_kind, line_no, new_depth, last);
      fails++;
      return;
    end
    want = owed_tokens.pop_front();
    checked++;
    if (want.kind == TOK_OVERFLOW) overflows++;
    if (want.kind == TOK_BAD_DEDENT) bad_dedents++;
    if (token_kind !== want.kind) begin
      $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
      fails++;
    end
    if (line_no !== want.line) begin
      $error("line_no: expected %0d, got %0d", want.line, line_no);
      fails++;
    end
    if (new_depth !== want.depth) begin
      $error("new_depth: expected %0d, got %0d", want.depth, new_depth);
      fails++;
    end
    if (last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, last);
      fails++;
    end
  endtask

  // Check tokens before predicting, so a stray token never meets a fresh expectation
  always @(posedge clk) begin
    if (rst) begin
      tab_cols   = TAB_WIDTH_RESET;
      line_phase = AT_LINE_START;
      col        = '0;
      levels[0]  = '0;
      level_top  = '0;
      line_cnt   = LINE_BITS'(1);
      owed_tokens.delete();
    end else begin
      if (out_valid && !out_stall) check_token();
      if (cfg_we) tab_cols = cfg_wdata;
      if (in_valid && !in_stall) advance_byte(ch, in_brackets);
    end
    fail_count       <= fails;
    tokens_owed      <= owed_tokens.size();
    tokens_checked   <= checked;
    overflows_seen   <= overflows;
    bad_dedents_seen <= bad_dedents;
  end

endmodule

// ----- tb/sv/indent_dedent_tracker_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indent_dedent_tracker_top_test: stimulus and verdict for the indent tracker
// Feeds shaped source lines (code, blank, comment, bracketed, cut by end of
// input) and raw noise bytes under several tab widths and pacing modes. The
// token checker beside the block predicts and scores every token; this module
// drives, paces, watches for a hang and prints the verdict.
// ----------------------------------------------------------------------------
module indent_dedent_tracker_top_test;
  import idt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  // Enough for the command queue to drain lines that cause no token
  localparam int SETTLE_CYCLES  = 16;

  typedef enum {
    SHAPE_CODE,
    SHAPE_BLANK,
    SHAPE_COMMENT,
    SHAPE_BRACKET,
    SHAPE_EOI
  } line_shape_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CH_W-1:0]      ch = '0;
  logic                 in_brackets = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           token_kind;
  logic [LINE_NO_W-1:0] line_no;
  logic [DEPTH_W-1:0]   new_depth;
  logic                 last;
  logic                 cfg_we = 1'b0;
  logic [TAB_W-1:0]     cfg_wdata = '0;

  int fail_count;
  int tokens_owed;
  int tokens_checked;
  int overflows_seen;
  int bad_dedents_seen;

  int               send_idle = 0;
  int               recv_stall = 0;
  int               quiet_cycles = 0;
  int               bytes_driven = 0;
  int               shaped_bytes = 0;
  int               tab_settings = 1;
  int               prev_cols = 0;
  logic [TAB_W-1:0] cur_tab = TAB_WIDTH_RESET;

  indent_dedent_tracker_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ch          (ch),
    .in_brackets (in_brackets),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .line_no     (line_no),
    .new_depth   (new_depth),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  idt_token_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .ch               (ch),
    .in_brackets      (in_brackets),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .token_kind       (token_kind),
    .line_no          (line_no),
    .new_depth        (new_depth),
    .last             (last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .tokens_owed      (tokens_owed),
    .tokens_checked   (tokens_checked),
    .overflows_seen   (overflows_seen),
    .bad_dedents_seen (bad_dedents_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver side: stall the token channel at the current rate
  always @(posedge clk) begin
    out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
  end

  // Watchdog: count cycles in which neither channel completes a transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles, %0d tokens still owed", quiet_cycles,
             tokens_owed);
      $display("FAIL indent_dedent_tracker_top");
      $finish;
    end
  end

  // Present one byte and hold it until the block takes it. Valid stays high
  // after the transaction so back-to-back bytes need no second assignment.
  task automatic drive_byte(input logic [CH_W-1:0] c, input logic brk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    ch          <= c;
    in_brackets <= brk;
    bytes_driven++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, then wait until every owed token is out and the queue settles
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (tokens_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tab(input logic [TAB_W-1:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_tab = w;
    tab_settings++;
  endtask

  task automatic set_pace(input int s, input int r);
    send_idle  = s;
    recv_stall = r;
  endtask

  // Any byte that ends a line's indentation as code (no EOI, tab, newline, space or '#')
  function automatic logic [CH_W-1:0] lead_byte();
    logic [CH_W-1:0] b;
    b = CH_W'($urandom_range(1, 255));
    while (b == CH_TAB || b == CH_NL || b == CH_SPACE || b == CH_HASH)
      b = CH_W'($urandom_range(1, 255));
    return b;
  endfunction

  function automatic logic [CH_W-1:0] body_byte();
    logic [CH_W-1:0] b;
    b = CH_W'($urandom_range(1, 255));
    if (b == CH_NL) b = CH_SPACE;
    return b;
  endfunction

  // Build the column count from a mix of tabs and spaces; long runs lean on
  // tabs. With a tab width of zero, scatter tabs that add nothing.
  task automatic indent_to(input int cols);
    int rem;
    rem = cols;
    while (rem > 0) begin
      if (cur_tab != 0 && rem >= cur_tab && (rem > 40 || $urandom_range(1))) begin
        drive_byte(CH_TAB, 1'b0);
        rem -= cur_tab;
      end else begin
        drive_byte(CH_SPACE, 1'b0);
        rem--;
      end
      shaped_bytes++;
      if (cur_tab == 0 && $urandom_range(7) == 0) begin
        drive_byte(CH_TAB, 1'b0);
        shaped_bytes++;
      end
    end
  endtask

  // Rest of a line: the block ignores it, so it is not counted
  task automatic body_tail();
    repeat ($urandom_range(0, 3)) drive_byte(body_byte(), 1'($urandom_range(1)));
  endtask

  task automatic send_line(input int cols, input line_shape_t shape);
    indent_to(cols);
    case (shape)
      SHAPE_CODE: begin
        drive_byte(lead_byte(), 1'b0);
        shaped_bytes++;
        body_tail();
      end
      SHAPE_BLANK: ;
      SHAPE_COMMENT: begin
        drive_byte(CH_HASH, 1'b0);
        shaped_bytes++;
        body_tail();
      end
      SHAPE_BRACKET: begin
        // Continuation line: the bracket flag wins over spaces, tabs and '#'
        drive_byte(body_byte(), 1'b1);
        shaped_bytes++;
        body_tail();
      end
      SHAPE_EOI: begin
        if ($urandom_range(1)) begin
          drive_byte(lead_byte(), 1'b0);
          shaped_bytes++;
          body_tail();
        end
      end
    endcase
    drive_byte((shape == SHAPE_EOI) ? CH_EOI : CH_NL, 1'($urandom_range(1)));
    shaped_bytes++;
  endtask

  // Mostly well-formed lines that walk the nesting up and down on a grid of
  // the tab width (four for a width of zero), with off-grid columns for
  // inconsistent dedents and a few bursts of raw bytes.
  task automatic random_lines(input int budget);
    int          stop_at;
    int          r;
    int          cols;
    int          unit;
    line_shape_t shape;
    stop_at = shaped_bytes + budget;
    unit = (cur_tab == 0) ? 4 : cur_tab;
    while (shaped_bytes < stop_at) begin
      r = $urandom_range(99);
      if (r < 5) begin
        repeat ($urandom_range(1, 4)) begin
          drive_byte(CH_W'($urandom_range(255)), 1'($urandom_range(1)));
          shaped_bytes++;
        end
      end else begin
        case ($urandom_range(99)) inside
          [0:29]:  cols = prev_cols;
          [30:54]: cols = prev_cols + unit;
          [55:79]: cols = unit * $urandom_range(0, prev_cols / unit);
          [80:94]: cols = $urandom_range(0, prev_cols + unit);
          default: cols = $urandom_range(0, 120);
        endcase
        if (cols > 34 * unit) cols = 0;
        if (r < 72)      shape = SHAPE_CODE;
        else if (r < 80) shape = SHAPE_BLANK;
        else if (r < 88) shape = SHAPE_COMMENT;
        else if (r < 95) shape = SHAPE_BRACKET;
        else             shape = SHAPE_EOI;
        send_line(cols, shape);
        if (shape == SHAPE_CODE) prev_cols = cols;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines at the reset tab width of four
    set_pace(0, 0);
    send_line(4, SHAPE_CODE);      // open one level
    send_line(8, SHAPE_CODE);      // open a second
    send_line(2, SHAPE_CODE);      // two dedents, then no level matches
    send_line(6, SHAPE_BLANK);     // blank line, skipped
    send_line(12, SHAPE_COMMENT);  // comment-only line, skipped
    send_line(9, SHAPE_BRACKET);   // continuation line, skipped
    send_line(3, SHAPE_EOI);       // end of input: no line counted
    send_line(1, SHAPE_CODE);
    drive_byte(8'hFF, 1'b0);       // top byte value closes the level at column 0
    drive_byte(CH_NL, 1'b1);
    wait_quiet();

    // Random phases: one per pacing mode, with tab widths that include both extremes
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: set_pace(0, 0);
        1: set_pace(48, 0);
        2: set_pace(0, 48);
        default: set_pace(11, 11);
      endcase
      case (i)
        0: set_tab(4'd1);
        1: set_tab(4'd0);
        2: set_tab(4'd15);
        default: set_tab(4'd3);
      endcase
      prev_cols = 0;
      random_lines(24);
      wait_quiet();
    end

    // Nest past the full stack, then close all levels with one byte
    set_pace(11, 11);
    set_tab(4'd8);
    for (int k = 1; k <= 34; k++) send_line(k, SHAPE_CODE);
    send_line(0, SHAPE_CODE);
    wait_quiet();

    $display("covered %0d bytes over %0d tab widths, %0d tokens checked",
             bytes_driven, tab_settings, tokens_checked);
    $display("  incl. %0d overflows, %0d inconsistent dedents, full stack",
             overflows_seen, bad_dedents_seen);
    if (fail_count == 0) begin
      $display("PASS indent_dedent_tracker_top");
    end else begin
      $display("FAIL indent_dedent_tracker_top");
    end
    $finish;
  end

endmodule

// ----- indent_dedent_tracker_top.f -----
design/idt_pkg.sv
design/idt_ram.sv
design/idt_front.sv
design/idt_queue.sv
design/idt_back.sv
design/indent_dedent_tracker_top.sv
tb/sv/idt_token_checker.sv
tb/sv/indent_dedent_tracker_top_test.sv
